FILE: hw/rtl/indexed_list_store_macros.svh
// Assertion macros for the indexed list store RTL.
`ifndef INDEXED_LIST_STORE_MACROS_SVH
`define INDEXED_LIST_STORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ILS_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ILS_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: hw/rtl/ils_pkg.sv
// Types, codes and elaboration helpers for the indexed list store.
package ils_pkg;

    // Request kinds
    typedef enum logic [2:0] {
        KIND_GET    = 3'd0,
        KIND_SET    = 3'd1,
        KIND_APPEND = 3'd2,
        KIND_POP    = 3'd3,
        KIND_INSERT = 3'd4,
        KIND_REMOVE = 3'd5
    } kind_t;

    // Response status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Per-cell update command
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_WRITE  = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_REMOVE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     rd;
    } cell_cmd_t;

    // Control sequencer states
    typedef enum logic [1:0] {
        ILS_IDLE = 2'd0,
        ILS_WALK = 2'd1,
        ILS_DONE = 2'd2
    } state_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  index;
        logic [31:0] item;
    } req_t;

    typedef struct packed {
        logic [31:0] value;
        logic [8:0]  count;
        logic [1:0]  status;
    } rsp_t;

    // Read tree fan-in per node
    localparam int ILS_FANIN     = 8;
    localparam int ILS_FANIN_LOG = 3;

    // Nodes at a tree level; level 0 is the leaf row.
    function automatic int tree_width(input int leaves, input int lvl);
        int w;
        w = leaves;
        for (int k = 0; k < lvl; k++) begin
            w = (w + ILS_FANIN - 1) >> ILS_FANIN_LOG;
        end
        return w;
    endfunction

    // Registered levels needed to reduce the leaf row to one node.
    function automatic int tree_levels(input int leaves);
        int lv;
        int w;
        lv = 1;
        w  = (leaves + ILS_FANIN - 1) >> ILS_FANIN_LOG;
        for (int k = 0; k < 8; k++) begin
            if (w > 1) begin
                w  = (w + ILS_FANIN - 1) >> ILS_FANIN_LOG;
                lv = lv + 1;
            end
        end
        return lv;
    endfunction

    // Position of the first node of a level in the flat node array.
    function automatic int tree_offset(input int leaves, input int lvl);
        int off;
        off = 0;
        for (int k = 1; k < lvl; k++) begin
            off = off + tree_width(leaves, k);
        end
        return off;
    endfunction

endpackage

FILE: hw/rtl/ils_cell.sv
// One list slot: holds an entry and shifts with its neighbors.
module ils_cell #(
    parameter int POS   = 0,
    parameter int CNT_W = 9,
    parameter int WIDTH = 32
) (
    input  logic              clk,
    input  ils_pkg::cell_cmd_t cmd,
    input  logic [CNT_W-1:0]  wr_pos,
    input  logic [CNT_W-1:0]  end_pos,
    input  logic [CNT_W-1:0]  rd_pos,
    input  logic [WIDTH-1:0]  item,
    input  logic [WIDTH-1:0]  lower,
    input  logic [WIDTH-1:0]  upper,
    output logic [WIDTH-1:0]  data,
    output logic [WIDTH-1:0]  leaf
);

    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(POS);

    logic [WIDTH-1:0] data_reg;
    logic [WIDTH-1:0] data_next;
    logic             at_wr;
    logic             above_wr;
    logic             below_end;
    logic             at_end;

    assign at_wr     = (MY_POS == wr_pos);
    assign above_wr  = (MY_POS > wr_pos);
    assign below_end = (MY_POS < end_pos);
    assign at_end    = (MY_POS == end_pos);

    always_comb
    begin
        case (cmd.op)
            ils_pkg::CELL_HOLD:
            begin
                data_next = data_reg;
            end
            ils_pkg::CELL_WRITE:
            begin
                data_next = at_wr ? item : data_reg;
            end
            ils_pkg::CELL_INSERT:
            begin
                // open a gap at wr_pos, take the lower neighbor up to end_pos
                if (at_wr)
                    data_next = item;
                else if (above_wr && (below_end || at_end))
                    data_next = lower;
                else
                    data_next = data_reg;
            end
            ils_pkg::CELL_REMOVE:
            begin
                // close the gap: slots from wr_pos up to just below end_pos take the upper neighbor
                data_next = ((at_wr || above_wr) && below_end) ? upper : data_reg;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign leaf = (cmd.rd && (MY_POS == rd_pos)) ? data_reg : '0;

endmodule

FILE: hw/rtl/ils_read_tree.sv
// Registered OR tree that gathers the one selected cell onto the read port.
module ils_read_tree #(
    parameter int LEAVES = 256,
    parameter int WIDTH  = 32
) (
    input  logic             clk,
    input  logic             advance,
    input  logic [WIDTH-1:0] leaf [LEAVES],
    output logic [WIDTH-1:0] root
);

    localparam int LEVELS = ils_pkg::tree_levels(LEAVES);
    localparam int TOTAL  = ils_pkg::tree_offset(LEAVES, LEVELS + 1);

    logic [WIDTH-1:0] node_reg  [TOTAL];
    logic [WIDTH-1:0] node_next [TOTAL];

    for (genvar l = 1; l <= LEVELS; l++)
    begin : g_lvl
        localparam int NW   = ils_pkg::tree_width(LEAVES, l);
        localparam int PW   = ils_pkg::tree_width(LEAVES, l - 1);
        localparam int OFF  = ils_pkg::tree_offset(LEAVES, l);
        localparam int POFF = ils_pkg::tree_offset(LEAVES, l - 1);

        for (genvar j = 0; j < NW; j++)
        begin : g_node
            logic [WIDTH-1:0] part [ils_pkg::ILS_FANIN];
            logic [WIDTH-1:0] node_or;

            for (genvar k = 0; k < ils_pkg::ILS_FANIN; k++)
            begin : g_kid
                if (j * ils_pkg::ILS_FANIN + k >= PW)
                begin : g_pad
                    assign part[k] = '0;
                end
                else if (l == 1)
                begin : g_leaf
                    assign part[k] = leaf[j * ils_pkg::ILS_FANIN + k];
                end
                else
                begin : g_inner
                    assign part[k] = node_reg[POFF + j * ils_pkg::ILS_FANIN + k];
                end
            end

            always_comb
            begin
                node_or = '0;
                for (int k = 0; k < ils_pkg::ILS_FANIN; k++) begin
                    node_or = node_or | part[k];
                end
            end

            assign node_next[OFF + j] = node_or;
        end
    end

    // freeze while a finished read waits on the response port
    always_ff @(posedge clk)
    begin
        if (advance)
            node_reg <= node_next;
    end

    assign root = node_reg[TOTAL-1];

endmodule

FILE: hw/rtl/indexed_list_store.sv
// Top level of the indexed list store: request decode, cell row, read tree, control.
//
//  channel | dir | payload               | handshake
//  --------+-----+-----------------------+---------------------
//  req     | in  | kind, index, item     | req_valid / req_ready
//  rsp     | out | value, count, status  | rsp_valid / rsp_ready
//
// One request at a time; the read passes through the 8-way registered read tree, LEVELS levels deep.
// All shifts and writes land in the cell row at the accepting edge.
// The read walks the tree one level a cycle, then the response beat is offered.
// A stalled response holds the tree and keeps req_ready low until the beat leaves.
// Reset empties the list; slot contents are not cleared.
`include "indexed_list_store_macros.svh"

module indexed_list_store #(
    parameter int CAPACITY   = 256,
    parameter int ITEM_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ils_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ils_pkg::rsp_t rsp
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > 8) ? CNT_W : 8;
    localparam int LEVELS = ils_pkg::tree_levels(CAPACITY);
    localparam int WAIT_W = (LEVELS > 2) ? $clog2(LEVELS - 1) : 1;

    ils_pkg::state_t    state_reg;
    ils_pkg::state_t    state_next;
    logic [WAIT_W-1:0]  wait_reg;
    logic [WAIT_W-1:0]  wait_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;

    logic               accept;
    logic               tree_advance;
    logic               idx_ok;
    logic               full;
    logic [CNT_W-1:0]   idx_pos;
    logic [CNT_W-1:0]   count_up;
    logic [CNT_W-1:0]   count_dn;
    ils_pkg::cell_op_t  op;
    logic               rd_en;
    ils_pkg::cell_cmd_t cmd;
    logic [CNT_W-1:0]   wr_pos;
    logic [CNT_W-1:0]   end_pos;
    logic [CNT_W-1:0]   rd_pos;
    logic [ITEM_WIDTH-1:0] item_w;
    logic [ITEM_WIDTH-1:0] root;

    logic [ITEM_WIDTH-1:0] cell_data [CAPACITY];
    logic [ITEM_WIDTH-1:0] cell_lo   [CAPACITY];
    logic [ITEM_WIDTH-1:0] cell_hi   [CAPACITY];
    logic [ITEM_WIDTH-1:0] cell_leaf [CAPACITY];

    assign accept   = req_valid && req_ready;
    assign idx_ok   = CMP_W'(req.index) < CMP_W'(count_reg);
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign idx_pos  = CNT_W'(req.index);
    assign count_up = count_reg + 1'b1;
    assign count_dn = count_reg - 1'b1;
    assign item_w   = ITEM_WIDTH'(req.item);

    // request decode
    always_comb
    begin
        op          = ils_pkg::CELL_HOLD;
        rd_en       = 1'b0;
        wr_pos      = idx_pos;
        end_pos     = count_reg;
        rd_pos      = idx_pos;
        status_next = ils_pkg::ST_OK;
        count_next  = count_reg;
        case (req.kind)
            ils_pkg::KIND_GET:
            begin
                if (idx_ok)
                    rd_en = 1'b1;
                else
                    status_next = ils_pkg::ST_RANGE;
            end
            ils_pkg::KIND_SET:
            begin
                if (idx_ok)
                    op = ils_pkg::CELL_WRITE;
                else
                    status_next = ils_pkg::ST_RANGE;
            end
            ils_pkg::KIND_APPEND:
            begin
                if (full) begin
                    status_next = ils_pkg::ST_FULL;
                end
                else begin
                    op         = ils_pkg::CELL_WRITE;
                    wr_pos     = count_reg;
                    count_next = count_up;
                end
            end
            ils_pkg::KIND_POP:
            begin
                if (count_reg == '0) begin
                    status_next = ils_pkg::ST_RANGE;
                end
                else begin
                    rd_en      = 1'b1;
                    rd_pos     = count_dn;
                    count_next = count_dn;
                end
            end
            ils_pkg::KIND_INSERT:
            begin
                if (!idx_ok) begin
                    status_next = ils_pkg::ST_RANGE;
                end
                else if (full) begin
                    status_next = ils_pkg::ST_FULL;
                end
                else begin
                    op         = ils_pkg::CELL_INSERT;
                    count_next = count_up;
                end
            end
            ils_pkg::KIND_REMOVE:
            begin
                if (!idx_ok) begin
                    status_next = ils_pkg::ST_RANGE;
                end
                else begin
                    op         = ils_pkg::CELL_REMOVE;
                    rd_en      = 1'b1;
                    end_pos    = count_dn;
                    count_next = count_dn;
                end
            end
            default:
            begin
                status_next = ils_pkg::ST_RANGE;
            end
        endcase
    end

    assign cmd.op = accept ? op : ils_pkg::CELL_HOLD;
    assign cmd.rd = accept && rd_en;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign cell_lo[i] = '0;
        end
        else
        begin : g_lo
            assign cell_lo[i] = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign cell_hi[i] = '0;
        end
        else
        begin : g_hi
            assign cell_hi[i] = cell_data[i+1];
        end

        ils_cell #(
            .POS   (i),
            .CNT_W (CNT_W),
            .WIDTH (ITEM_WIDTH)
        ) u_cell (
            .clk     (clk),
            .cmd     (cmd),
            .wr_pos  (wr_pos),
            .end_pos (end_pos),
            .rd_pos  (rd_pos),
            .item    (item_w),
            .lower   (cell_lo[i]),
            .upper   (cell_hi[i]),
            .data    (cell_data[i]),
            .leaf    (cell_leaf[i])
        );
    end

    ils_read_tree #(
        .LEAVES (CAPACITY),
        .WIDTH  (ITEM_WIDTH)
    ) u_read_tree (
        .clk     (clk),
        .advance (tree_advance),
        .leaf    (cell_leaf),
        .root    (root)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        wait_next  = wait_reg;
        case (state_reg)
            ils_pkg::ILS_IDLE:
            begin
                if (accept) begin
                    state_next = (LEVELS > 1) ? ils_pkg::ILS_WALK : ils_pkg::ILS_DONE;
                    wait_next  = (LEVELS > 1) ? WAIT_W'(LEVELS - 2) : '0;
                end
            end
            ils_pkg::ILS_WALK:
            begin
                if (wait_reg == '0)
                    state_next = ils_pkg::ILS_DONE;
                else
                    wait_next = wait_reg - 1'b1;
            end
            ils_pkg::ILS_DONE:
            begin
                if (rsp_ready)
                    state_next = ils_pkg::ILS_IDLE;
            end
            default:
            begin
                state_next = ils_pkg::ILS_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready    = 1'b0;
        rsp_valid    = 1'b0;
        tree_advance = 1'b1;
        case (state_reg)
            ils_pkg::ILS_IDLE:
            begin
                req_ready = 1'b1;
            end
            ils_pkg::ILS_WALK:
            begin
                req_ready = 1'b0;
            end
            ils_pkg::ILS_DONE:
            begin
                rsp_valid    = 1'b1;
                tree_advance = 1'b0;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ils_pkg::ILS_IDLE;
            wait_reg  <= '0;
            count_reg <= '0;
        end
        else begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            if (accept)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            status_reg <= status_next;
    end

    assign rsp.value  = 32'(root);
    assign rsp.count  = 9'(count_reg);
    assign rsp.status = status_reg;

    `ILS_ASSERT_NEXT(a_one_in_flight, accept, !req_ready, "request taken while one is in flight")
    `ILS_ASSERT_NEXT(a_count_hold, !accept, $stable(count_reg), "count moved without a request beat")
    `ILS_ASSERT_NOW(a_full_status, rsp_valid && (rsp.status == ils_pkg::ST_FULL), count_reg == CNT_W'(CAPACITY), "full status with room left")
    `ILS_ASSERT_NEXT(a_append_grows, accept && (req.kind == ils_pkg::KIND_APPEND) && !full, count_reg == CNT_W'($past(count_reg) + 1'b1), "append did not grow the list")

endmodule
